// ===== rtl/binary_lifting_lca_unit_assert.svh =====
// Assertion macros shared by the tree engine RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BINARY_LIFTING_LCA_UNIT_ASSERT_SVH
`define BINARY_LIFTING_LCA_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BLCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BLCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/blca_pkg.sv =====
// ----------------------------------------------------------------------------
// blca_pkg
// Types and fixed constants of the binary lifting tree engine.
// ----------------------------------------------------------------------------
package blca_pkg;

  localparam int NODE_W     = 10;
  localparam int NCOUNT_W   = 11;
  localparam int WD_W       = 32;
  localparam int DIST_W     = 33;
  localparam int CFG_DATA_W = 11;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_LCA   = 2'd2,
    FUNC_KTH   = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    CFG_NODE_COUNT = 1'b0,
    CFG_ROOT_NODE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] parent_node;
    logic              has_parent;
    logic [NODE_W-1:0] hop_depth;
    logic [WD_W-1:0]   weighted_depth;
    logic [NODE_W-1:0] step_count;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] result_node;
    logic [DIST_W-1:0] distance;
    logic              has_result;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_DONE,
    S_BLD_START,
    S_BLD_RD,
    S_BLD_CHK,
    S_BLD_WR,
    S_Q_RDA,
    S_Q_RDB,
    S_Q_SWAP,
    S_Q_EQ,
    S_Q_MID,
    S_Q_X,
    S_Q_Y,
    S_Q_RDL,
    S_Q_DIST,
    S_Q_FIN,
    S_K_FIN,
    S_L_INFO,
    S_L_CHK,
    S_L_STEP,
    S_L_WAIT
  } state_t;

endpackage

// ===== rtl/blca_nmod.sv =====
// ----------------------------------------------------------------------------
// blca_nmod
// Reduces a 10-bit node number modulo the node capacity.
// ----------------------------------------------------------------------------
module blca_nmod import blca_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int NW        = 10
) (
  input  logic [NODE_W-1:0] raw,
  output logic [NW-1:0]     node
);

  logic [26:0] rem;

  // Restoring reduction: subtract shifted copies of the capacity, high to low.
  always_comb begin
    rem = 27'(raw);
    for (int t = NODE_W - 1; t >= 0; t--) begin
      if (rem >= (27'(MAX_NODES) << t)) begin
        rem = rem - (27'(MAX_NODES) << t);
      end
    end
  end

  assign node = NW'(rem);

endmodule

// ===== rtl/blca_ram.sv =====
// ----------------------------------------------------------------------------
// blca_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module blca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/binary_lifting_lca_unit.sv =====
// ----------------------------------------------------------------------------
// binary_lifting_lca_unit
// Tree engine: node load, ancestor table build, LCA with distance, k-th ancestor.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the item is taken on a rising edge with
// start high and busy low. busy stays high until the item finishes. Each item
// gives exactly one result, shown on out_data for one cycle with out_valid high;
// the receiver cannot stall, and busy falls in that same cycle so that the next
// item may be taken at once. Configuration (node_count, root_node) is written
// over cfg_valid/cfg_ready/cfg_index/cfg_wdata while the engine is idle.
// Steps: load writes one table row, an entry per cycle. Build fills levels 1 to
// LEVELS-1 node by node, with one or two table reads and one write per entry.
// The k-th ancestor walk takes jumps of the largest power of two not above the
// remaining count, capped at the top level. LCA lifts the deeper node to equal
// depth, then binary-searches the lift height in rounds of two walks each, one
// from each node.
// Reset clears control state and root_node and sets node_count to 1024; the stores
// hold nothing meaningful until each node is loaded, and no clearing pass is run.
// ----------------------------------------------------------------------------
`include "binary_lifting_lca_unit_assert.svh"

module binary_lifting_lca_unit import blca_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  in_t                   in_data,
  output logic                  busy,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TD   = MAX_NODES * LEVELS;
  localparam int AW   = $clog2(TD);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int CW   = (NCW > NCOUNT_W) ? NCW : NCOUNT_W;
  localparam int IW   = NODE_W + WD_W;

  function automatic logic [AW-1:0] anc_addr(input logic [NW-1:0] nd,
                                             input logic [LW-1:0] lv);
    anc_addr = AW'(nd) * AW'(LEVELS) + AW'(lv);
  endfunction

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  logic [NCOUNT_W-1:0] node_count_r;
  logic [NODE_W-1:0]   root_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic [NW-1:0]     a_r, a_nxt, b_r, b_nxt, par_r, par_nxt;
  logic              hasp_r, hasp_nxt;
  logic [NODE_W-1:0] hopin_r, hopin_nxt;
  logic [WD_W-1:0]   wdin_r, wdin_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt, j_r, j_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [NODE_W-1:0] hop_a_r, hop_a_nxt, hv_r, hv_nxt, mid_r, mid_nxt;
  logic [WD_W-1:0]   wd_a_r, wd_a_nxt, wd_b_r, wd_b_nxt;
  logic [NW-1:0]     u_r, u_nxt, v_r, v_nxt, best_r, best_nxt, x_r, x_nxt, l_r, l_nxt;
  logic [NODE_W:0]   lo_r, lo_nxt, hi1_r, hi1_nxt;
  logic [DIST_W-1:0] sum_r, sum_nxt, sub_r, sub_nxt;
  logic [NW-1:0]     lu_r, lu_nxt, cur_r, cur_nxt, lres_r, lres_nxt;
  logic [NODE_W-1:0] lk_r, lk_nxt, left_r, left_nxt;

  logic [NW-1:0] a_norm, b_norm, par_norm, root_norm;

  logic          anc_we, anc_re;
  logic [AW-1:0] anc_waddr, anc_raddr;
  logic [NW:0]   anc_wdata, anc_rdata;
  logic          info_we, info_re;
  logic [NW-1:0] info_waddr, info_raddr;
  logic [IW-1:0] info_wdata, info_rdata;

  logic [NODE_W-1:0] rd_hop;
  logic [WD_W-1:0]   rd_wd;
  logic              rd_valid;
  logic [NW-1:0]     rd_idx;
  logic              accept;
  logic [CW-1:0]     n_eff;
  logic              bld_last_i, bld_last_j;
  logic [NODE_W:0]   msum;
  logic [NODE_W-1:0] mid_c;
  logic [3:0]        msb;
  logic [LW-1:0]     step_lvl;
  logic              swap;

  blca_nmod #(.MAX_NODES(MAX_NODES), .NW(NW)) u_nmod_a (.raw(in_data.node_a), .node(a_norm));
  blca_nmod #(.MAX_NODES(MAX_NODES), .NW(NW)) u_nmod_b (.raw(in_data.node_b), .node(b_norm));
  blca_nmod #(.MAX_NODES(MAX_NODES), .NW(NW)) u_nmod_p (
    .raw(in_data.parent_node), .node(par_norm));
  blca_nmod #(.MAX_NODES(MAX_NODES), .NW(NW)) u_nmod_r (.raw(root_r), .node(root_norm));

  blca_ram #(.WIDTH(NW + 1), .DEPTH(TD), .AW(AW)) u_anc_ram (
    .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
    .re(anc_re), .raddr(anc_raddr), .rdata(anc_rdata));

  blca_ram #(.WIDTH(IW), .DEPTH(MAX_NODES), .AW(NW)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .re(info_re), .raddr(info_raddr), .rdata(info_rdata));

  assign rd_hop   = info_rdata[WD_W +: NODE_W];
  assign rd_wd    = info_rdata[WD_W-1:0];
  assign rd_valid = anc_rdata[NW];
  assign rd_idx   = anc_rdata[NW-1:0];

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_eff = (CW'(node_count_r) >= CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_r);
  assign bld_last_i = ((i_r + CW'(1)) == n_eff);
  assign bld_last_j = (j_r == LW'(LEVELS - 1));
  assign msum  = lo_r + hi1_r - (NODE_W + 1)'(1);
  assign mid_c = msum[NODE_W:1];
  assign swap  = (hop_a_r < rd_hop);

  // Largest jump not above the remaining count, capped at the top level.
  always_comb begin
    msb = '0;
    for (int t = 0; t < NODE_W; t++) begin
      if (left_r[t]) begin
        msb = 4'(t);
      end
    end
    if (5'(msb) > 5'(LEVELS - 1)) begin
      step_lvl = LW'(LEVELS - 1);
    end else begin
      step_lvl = LW'(msb);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func_t'(in_data.func))
            FUNC_LOAD:  state_nxt = S_LOAD;
            FUNC_BUILD: state_nxt = S_BLD_START;
            FUNC_LCA:   state_nxt = S_Q_RDA;
            default:    state_nxt = S_L_INFO;
          endcase
        end
      end
      S_LOAD:      if (lvl_r == LW'(LEVELS - 1)) state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      S_BLD_START: begin
        if (n_eff == '0 || LEVELS == 1) state_nxt = S_DONE;
        else state_nxt = S_BLD_RD;
      end
      S_BLD_RD:    state_nxt = S_BLD_CHK;
      S_BLD_CHK: begin
        if (rd_valid) state_nxt = S_BLD_WR;
        else if (bld_last_i && bld_last_j) state_nxt = S_DONE;
        else state_nxt = S_BLD_RD;
      end
      S_BLD_WR: begin
        if (bld_last_i && bld_last_j) state_nxt = S_DONE;
        else state_nxt = S_BLD_RD;
      end
      S_Q_RDA:  state_nxt = S_Q_RDB;
      S_Q_RDB:  state_nxt = S_Q_SWAP;
      S_Q_SWAP: state_nxt = S_L_INFO;
      S_Q_EQ: begin
        if (lres_r == v_r) state_nxt = S_Q_RDL;
        else state_nxt = S_Q_MID;
      end
      S_Q_MID: begin
        if (lo_r < hi1_r) state_nxt = S_L_INFO;
        else state_nxt = S_Q_RDL;
      end
      S_Q_X:    state_nxt = S_L_INFO;
      S_Q_Y:    state_nxt = S_Q_MID;
      S_Q_RDL:  state_nxt = S_Q_DIST;
      S_Q_DIST: state_nxt = S_Q_FIN;
      S_Q_FIN:  state_nxt = S_IDLE;
      S_K_FIN:  state_nxt = S_IDLE;
      S_L_INFO: state_nxt = S_L_CHK;
      S_L_CHK: begin
        if (lk_r > rd_hop) state_nxt = ret_r;
        else state_nxt = S_L_STEP;
      end
      S_L_STEP: begin
        if (left_r == '0) state_nxt = ret_r;
        else state_nxt = S_L_WAIT;
      end
      S_L_WAIT: begin
        if (!rd_valid) state_nxt = ret_r;
        else state_nxt = S_L_STEP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control and datapath updates.
  always_comb begin
    anc_we = 1'b0;  anc_waddr = '0;  anc_wdata = '0;
    anc_re = 1'b0;  anc_raddr = '0;
    info_we = 1'b0; info_waddr = '0; info_wdata = '0;
    info_re = 1'b0; info_raddr = '0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ret_nxt = ret_r;
    a_nxt = a_r; b_nxt = b_r; par_nxt = par_r; hasp_nxt = hasp_r;
    hopin_nxt = hopin_r; wdin_nxt = wdin_r;
    lvl_nxt = lvl_r; i_nxt = i_r; j_nxt = j_r;
    hop_a_nxt = hop_a_r; hv_nxt = hv_r; mid_nxt = mid_r;
    wd_a_nxt = wd_a_r; wd_b_nxt = wd_b_r;
    u_nxt = u_r; v_nxt = v_r; best_nxt = best_r; x_nxt = x_r; l_nxt = l_r;
    lo_nxt = lo_r; hi1_nxt = hi1_r; sum_nxt = sum_r; sub_nxt = sub_r;
    lu_nxt = lu_r; lk_nxt = lk_r; cur_nxt = cur_r; left_nxt = left_r; lres_nxt = lres_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt     = a_norm;
          b_nxt     = b_norm;
          par_nxt   = par_norm;
          hasp_nxt  = in_data.has_parent;
          hopin_nxt = in_data.hop_depth;
          wdin_nxt  = in_data.weighted_depth;
          lvl_nxt   = '0;
          lu_nxt    = a_norm;
          lk_nxt    = in_data.step_count;
          ret_nxt   = S_K_FIN;
        end
      end
      S_LOAD: begin
        anc_we    = 1'b1;
        anc_waddr = anc_addr(a_r, lvl_r);
        anc_wdata = (lvl_r == '0 && hasp_r) ? {1'b1, par_r} : '0;
        if (lvl_r == '0) begin
          info_we    = 1'b1;
          info_waddr = a_r;
          info_wdata = {hopin_r, wdin_r};
        end
        lvl_nxt = lvl_r + LW'(1);
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
      end
      S_BLD_START: begin
        i_nxt = '0;
        j_nxt = LW'(1);
      end
      S_BLD_RD: begin
        anc_re    = 1'b1;
        anc_raddr = anc_addr(i_r[NW-1:0], j_r - LW'(1));
      end
      S_BLD_CHK, S_BLD_WR: begin
        if (state_r == S_BLD_CHK && rd_valid) begin
          anc_re    = 1'b1;
          anc_raddr = anc_addr(rd_idx, j_r - LW'(1));
        end else begin
          anc_we    = 1'b1;
          anc_waddr = anc_addr(i_r[NW-1:0], j_r);
          anc_wdata = (state_r == S_BLD_WR) ? anc_rdata : '0;
          if (bld_last_i) begin
            i_nxt = '0;
            j_nxt = j_r + LW'(1);
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
      end
      S_Q_RDA: begin
        info_re    = 1'b1;
        info_raddr = a_r;
      end
      S_Q_RDB: begin
        hop_a_nxt  = rd_hop;
        wd_a_nxt   = rd_wd;
        info_re    = 1'b1;
        info_raddr = b_r;
      end
      S_Q_SWAP: begin
        wd_b_nxt = rd_wd;
        // The deeper node by hop depth is lifted to the other's depth.
        if (swap) begin
          u_nxt  = b_r;
          v_nxt  = a_r;
          hv_nxt = hop_a_r;
          lk_nxt = rd_hop - hop_a_r;
          lu_nxt = b_r;
        end else begin
          u_nxt  = a_r;
          v_nxt  = b_r;
          hv_nxt = rd_hop;
          lk_nxt = hop_a_r - rd_hop;
          lu_nxt = a_r;
        end
        ret_nxt = S_Q_EQ;
      end
      S_Q_EQ: begin
        u_nxt = lres_r;
        if (lres_r == v_r) begin
          l_nxt = lres_r;
        end else begin
          lo_nxt   = '0;
          hi1_nxt  = {1'b0, hv_r} + (NODE_W + 1)'(1);
          best_nxt = root_norm;
        end
      end
      S_Q_MID: begin
        // Binary search over the lift height; hi1 holds the upper bound plus one.
        if (lo_r < hi1_r) begin
          mid_nxt = mid_c;
          lu_nxt  = u_r;
          lk_nxt  = mid_c;
          ret_nxt = S_Q_X;
        end else begin
          l_nxt = best_r;
        end
      end
      S_Q_X: begin
        x_nxt   = lres_r;
        lu_nxt  = v_r;
        lk_nxt  = mid_r;
        ret_nxt = S_Q_Y;
      end
      S_Q_Y: begin
        if (x_r == lres_r) begin
          best_nxt = x_r;
          hi1_nxt  = {1'b0, mid_r};
        end else begin
          lo_nxt = {1'b0, mid_r} + (NODE_W + 1)'(1);
        end
      end
      S_Q_RDL: begin
        info_re    = 1'b1;
        info_raddr = l_r;
      end
      S_Q_DIST: begin
        sum_nxt = DIST_W'(wd_a_r) + DIST_W'(wd_b_r);
        sub_nxt = {rd_wd, 1'b0};
      end
      S_Q_FIN: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.result_node = NODE_W'(l_r);
        out_data_nxt.distance    = (sum_r > sub_r) ? (sum_r - sub_r) : '0;
        out_data_nxt.has_result  = 1'b1;
      end
      S_K_FIN: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.result_node = NODE_W'(lres_r);
        out_data_nxt.distance    = '0;
        out_data_nxt.has_result  = 1'b1;
      end
      S_L_INFO: begin
        info_re    = 1'b1;
        info_raddr = lu_r;
      end
      S_L_CHK: begin
        if (lk_r > rd_hop) begin
          lres_nxt = root_norm;
        end else begin
          cur_nxt  = lu_r;
          left_nxt = lk_r;
        end
      end
      S_L_STEP: begin
        if (left_r == '0) begin
          lres_nxt = cur_r;
        end else begin
          anc_re    = 1'b1;
          anc_raddr = anc_addr(cur_r, step_lvl);
          left_nxt  = left_r - (NODE_W'(1) << step_lvl);
        end
      end
      S_L_WAIT: begin
        // A missing ancestor ends the walk at the root.
        if (!rd_valid) lres_nxt = root_norm;
        else cur_nxt = rd_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= NODE_COUNT_RST;
      root_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_wdata[NCOUNT_W-1:0];
          CFG_ROOT_NODE:  root_r       <= cfg_wdata[NODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ret_r <= ret_nxt;
    a_r <= a_nxt; b_r <= b_nxt; par_r <= par_nxt; hasp_r <= hasp_nxt;
    hopin_r <= hopin_nxt; wdin_r <= wdin_nxt;
    lvl_r <= lvl_nxt; i_r <= i_nxt; j_r <= j_nxt;
    hop_a_r <= hop_a_nxt; hv_r <= hv_nxt; mid_r <= mid_nxt;
    wd_a_r <= wd_a_nxt; wd_b_r <= wd_b_nxt;
    u_r <= u_nxt; v_r <= v_nxt; best_r <= best_nxt; x_r <= x_nxt; l_r <= l_nxt;
    lo_r <= lo_nxt; hi1_r <= hi1_nxt; sum_r <= sum_nxt; sub_r <= sub_nxt;
    lu_r <= lu_nxt; lk_r <= lk_nxt; cur_r <= cur_nxt; left_r <= left_nxt;
    lres_r <= lres_nxt;
  end

  `BLCA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not make the engine busy")
  `BLCA_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe lasted more than one cycle")
  `BLCA_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result shown while an item is still at work")
  `BLCA_ASSERT_IMP(a_ack_zero, out_valid && !out_data.has_result, out_data.result_node == '0 && out_data.distance == '0, "acknowledgment carries nonzero payload")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary lifting tree engine. A directed table of
// items comes first, followed by random phases. Each phase loads a tree, builds
// the ancestor table and runs LCA and k-th ancestor queries. Every result is
// compared against an in-bench model of the tables or a directed expected value.
// ----------------------------------------------------------------------------
module testbench;
  import blca_pkg::*;

  localparam int NODES = 1024;
  localparam int LVLS  = 10;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  in_t                   in_data;
  logic                  busy;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  binary_lifting_lca_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the engine's tables and registers.
  bit                anc_ok [0:NODES*LVLS-1];
  logic [NODE_W-1:0] anc_up [0:NODES*LVLS-1];
  logic [NODE_W-1:0] hop_of [0:NODES-1];
  logic [WD_W-1:0]   wd_of  [0:NODES-1];
  logic [10:0]       count_reg;
  logic [9:0]        root_reg;

  out_t  pending[$];
  bit    loaded [0:NODES-1];
  int    loaded_list[$];
  int    errors;
  longint cycles;
  bit    no_gaps;
  row_t  rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [NODE_W-1:0] tree_lift(logic [NODE_W-1:0] u, int k);
    logic [NODE_W-1:0] cur;
    int left;
    int s;
    int e;
    cur = u;
    left = k;
    if (k > hop_of[u]) return root_reg;
    while (left != 0) begin
      s = 0;
      while (s + 1 < LVLS && (1 << (s + 1)) <= left) s++;
      left -= (1 << s);
      e = cur * LVLS + s;
      if (!anc_ok[e]) return root_reg;
      cur = anc_up[e];
    end
    return cur;
  endfunction

  function automatic logic [NODE_W-1:0] tree_lca(logic [NODE_W-1:0] u,
                                                 logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] t;
    logic [NODE_W-1:0] x;
    logic [NODE_W-1:0] y;
    logic [NODE_W-1:0] best;
    int lo;
    int hi;
    int mid;
    best = root_reg;
    if (hop_of[u] < hop_of[v]) begin
      t = u; u = v; v = t;
    end
    u = tree_lift(u, int'(hop_of[u]) - int'(hop_of[v]));
    if (u == v) return u;
    lo = 0;
    hi = hop_of[v];
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      x = tree_lift(u, mid);
      y = tree_lift(v, mid);
      if (x == y) begin
        best = x;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best;
  endfunction

  function automatic void tree_build();
    int n;
    int b;
    n = (count_reg < NODES) ? count_reg : NODES;
    for (int j = 1; j < LVLS; j++) begin
      for (int i = 0; i < n; i++) begin
        b = i * LVLS + j - 1;
        if (anc_ok[b]) begin
          anc_ok[i*LVLS+j] = anc_ok[anc_up[b]*LVLS+j-1];
          anc_up[i*LVLS+j] = anc_up[anc_up[b]*LVLS+j-1];
        end else begin
          anc_ok[i*LVLS+j] = 1'b0;
          anc_up[i*LVLS+j] = '0;
        end
      end
    end
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t r;
    logic [NODE_W-1:0] l;
    logic [DIST_W-1:0] sum;
    logic [DIST_W-1:0] sub;
    r = '0;
    case (func_t'(it.func))
      FUNC_LOAD: begin
        anc_ok[it.node_a*LVLS] = it.has_parent;
        anc_up[it.node_a*LVLS] = it.has_parent ? it.parent_node : '0;
        for (int k = 1; k < LVLS; k++) begin
          anc_ok[it.node_a*LVLS+k] = 1'b0;
          anc_up[it.node_a*LVLS+k] = '0;
        end
        hop_of[it.node_a] = it.hop_depth;
        wd_of[it.node_a] = it.weighted_depth;
      end
      FUNC_BUILD: tree_build();
      FUNC_LCA: begin
        l = tree_lca(it.node_a, it.node_b);
        sum = {1'b0, wd_of[it.node_a]} + {1'b0, wd_of[it.node_b]};
        sub = {wd_of[l], 1'b0};
        r.result_node = l;
        r.distance = (sum > sub) ? sum - sub : '0;
        r.has_result = 1'b1;
      end
      default: begin
        r.result_node = tree_lift(it.node_a, it.step_count);
        r.has_result = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending.pop_front();
        if (want.result_node !== out_data.result_node ||
            want.distance !== out_data.distance ||
            want.has_result !== out_data.has_result) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected node %0d dist %0h has %0b, got %0d %0h %0b",
                     want.result_node, want.distance, want.has_result,
                     out_data.result_node, out_data.distance, out_data.has_result);
        end
      end
    end
  end

  task automatic drain();
    start = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [10:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NODE_COUNT) count_reg = v;
    else root_reg = v[9:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send(in_t it, bit typed, out_t want);
    int gap;
    out_t p;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: gap = 0;
        7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(15, 60);
      endcase
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    p = predict_result(it);
    pending.push_back(typed ? want : p);
    if (it.func == FUNC_LOAD && !loaded[it.node_a]) begin
      loaded[it.node_a] = 1'b1;
      loaded_list.push_back(it.node_a);
    end
    @(negedge clk);
  endtask

  function automatic in_t mk(func_t f, int a, int b, int par, bit hp, int hop,
                             logic [31:0] wd, int k);
    in_t it;
    it.func = f;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    it.parent_node = NODE_W'(par);
    it.has_parent = hp;
    it.hop_depth = NODE_W'(hop);
    it.weighted_depth = wd;
    it.step_count = NODE_W'(k);
    return it;
  endfunction

  function automatic void add_row(in_t it, bit typed, out_t want);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  // Loads one node under a parent with consistent depths, or noise now and then.
  task automatic load_node(int a, int par, bit is_root);
    int hop;
    logic [31:0] wd;
    bit hp;
    hp = !is_root;
    hop = is_root ? 0 : (hop_of[par] < 1023 ? hop_of[par] + 1 : 1023);
    wd = is_root ? $urandom_range(0, 50) : wd_of[par] + $urandom_range(0, 5000);
    if ($urandom_range(0, 9) == 0) begin
      hop = $urandom_range(0, 1023);
      wd = $urandom;
      hp = $urandom_range(0, 1);
    end
    send(mk(FUNC_LOAD, a, $urandom_range(0, 1023), par, hp, hop, wd,
            $urandom_range(0, 1023)), 1'b0, '0);
  endtask

  task automatic run_queries(int nq);
    int a;
    int b;
    int k;
    for (int q = 0; q < nq; q++) begin
      a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) :
          ((hop_of[a] + 2 > 1023) ? 1023 : $urandom_range(0, hop_of[a] + 2));
      case ($urandom_range(0, 19))
        0: load_node(a, b, 1'b0);
        1: send(mk(FUNC_BUILD, a, b, $urandom_range(0, 1023), $urandom_range(0, 1),
                   $urandom_range(0, 1023), $urandom, k), 1'b0, '0);
        2, 3, 4, 5, 6, 7, 8, 9, 10:
          send(mk(FUNC_LCA, a, b, $urandom_range(0, 1023), $urandom_range(0, 1),
                  $urandom_range(0, 1023), $urandom, k), 1'b0, '0);
        default:
          send(mk(FUNC_KTH, a, b, $urandom_range(0, 1023), $urandom_range(0, 1),
                  $urandom_range(0, 1023), $urandom, k), 1'b0, '0);
      endcase
    end
  endtask

  // One phase: set registers, load a tree over the build range plus a few
  // scattered nodes, build it and query it.
  task automatic run_phase(int cnt, int root_cfg, int extra, int nq);
    int n;
    int nodes[$];
    int a;
    write_reg(CFG_NODE_COUNT, 11'(cnt));
    write_reg(CFG_ROOT_NODE, 11'(root_cfg));
    n = (cnt < NODES) ? cnt : NODES;
    for (int i = 0; i < n; i++) nodes.push_back(i);
    for (int i = 0; i < extra; i++) nodes.push_back($urandom_range(0, 1023));
    for (int i = 0; i < nodes.size(); i++) begin
      a = (i == 0) ? 0 : $urandom_range((i > 6) ? i - 6 : 0, i - 1);
      load_node(nodes[i], nodes[a], i == 0);
    end
    send(mk(FUNC_BUILD, 0, 0, 0, 1'b0, 0, '0, 0), 1'b0, '0);
    run_queries(nq);
  endtask

  initial begin
    out_t z;
    out_t w;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NODE_COUNT;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    count_reg = NODE_COUNT_RST;
    root_reg = '0;
    for (int i = 0; i < NODES * LVLS; i++) begin
      anc_ok[i] = 1'b0;
      anc_up[i] = '0;
    end
    for (int i = 0; i < NODES; i++) begin
      hop_of[i] = '0;
      wd_of[i] = '0;
      loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    z = '0;
    add_row(mk(FUNC_LOAD, 0, 0, 0, 1'b0, 0, 32'h0, 0), 1'b1, z);
    add_row(mk(FUNC_LOAD, 1023, 1023, 0, 1'b1, 1, 32'hFFFF_FFFF, 1023), 1'b1, z);
    add_row(mk(FUNC_LOAD, 1, 0, 1023, 1'b1, 2, 32'h5, 0), 1'b1, z);
    add_row(mk(FUNC_LOAD, 2, 0, 1, 1'b1, 3, 32'h8000_0000, 0), 1'b1, z);
    w = '{result_node: 1, distance: 0, has_result: 1'b1};
    add_row(mk(FUNC_KTH, 1, 0, 0, 1'b0, 0, 0, 0), 1'b1, w);
    w = '{result_node: 0, distance: 0, has_result: 1'b1};
    add_row(mk(FUNC_KTH, 1, 0, 0, 1'b0, 0, 0, 1023), 1'b1, w);
    // Before the build only single steps are linked, so this jump falls to the root.
    add_row(mk(FUNC_KTH, 2, 0, 0, 1'b0, 0, 0, 2), 1'b0, z);
    add_row(mk(FUNC_BUILD, 0, 0, 0, 1'b0, 0, 0, 0), 1'b1, z);
    add_row(mk(FUNC_KTH, 2, 0, 0, 1'b0, 0, 0, 2), 1'b0, z);
    add_row(mk(FUNC_KTH, 2, 0, 0, 1'b0, 0, 0, 3), 1'b0, z);
    add_row(mk(FUNC_LCA, 2, 1023, 0, 1'b0, 0, 0, 0), 1'b0, z);
    add_row(mk(FUNC_LCA, 1023, 2, 0, 1'b0, 0, 0, 0), 1'b0, z);
    add_row(mk(FUNC_LCA, 0, 0, 0, 1'b0, 0, 0, 0), 1'b0, z);
    add_row(mk(FUNC_LCA, 2, 2, 0, 1'b0, 0, 0, 0), 1'b0, z);
    // Node 1 sits below a much heavier parent, so its distance saturates.
    add_row(mk(FUNC_LCA, 1023, 1, 0, 1'b0, 0, 0, 0), 1'b0, z);
    add_row(mk(FUNC_LOAD, 3, 0, 1023, 1'b0, 2, 32'hFFFF_FFFF, 0), 1'b1, z);
    add_row(mk(FUNC_KTH, 3, 0, 0, 1'b0, 0, 0, 1), 1'b0, z);
    add_row(mk(FUNC_LCA, 3, 2, 0, 1'b0, 0, 0, 0), 1'b0, z);
    add_row(mk(FUNC_LOAD, 4, 0, 1023, 1'b1, 1023, 32'h1234_5678, 0), 1'b1, z);
    add_row(mk(FUNC_KTH, 4, 0, 0, 1'b0, 0, 0, 1023), 1'b0, z);
    add_row(mk(FUNC_LOAD, 5, 0, 0, 1'b1, 1, 32'hFFFF_FFFF, 0), 1'b1, z);
    w = '{result_node: 0, distance: 33'h1_FFFF_FFFE, has_result: 1'b1};
    add_row(mk(FUNC_LCA, 5, 1023, 0, 1'b0, 0, 0, 0), 1'b1, w);

    write_reg(CFG_NODE_COUNT, 11'd2);
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

    run_phase(0, 1023, 8, 20);
    run_phase(1, 0, 6, 20);
    // A queried root must already hold loaded depths, so pick it from loaded nodes.
    for (int p = 0; p < 4; p++) begin
      no_gaps = (p == 2);
      run_phase($urandom_range(2, 40), ($urandom_range(0, 3) == 0) ?
                loaded_list[$urandom_range(0, loaded_list.size() - 1)] : 0,
                $urandom_range(0, 10), 25);
    end
    no_gaps = 1'b0;
    run_phase(2047, 1023, 0, 40);

    drain();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
